FILE: src/tasw_pkg.sv
// Shared types and constants for the tar archive stream walker.
package tasw_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned OFF_W = 9;

  // Header field positions inside a 512-byte block
  localparam logic [OFF_W-1:0] OFF_NAME      = 9'd0;
  localparam logic [OFF_W-1:0] OFF_SIZE_FIRST = 9'd124;
  localparam logic [OFF_W-1:0] OFF_SIZE_LAST  = 9'd135;
  localparam logic [OFF_W-1:0] OFF_TYPE      = 9'd156;
  localparam logic [OFF_W-1:0] OFF_PREFIX    = 9'd345;
  localparam logic [OFF_W-1:0] OFF_BLOCK_END = 9'd511;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_FIVE  = 8'h35;

  // Result kinds
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] size;
    logic        is_dir;
    logic        named;
    logic [7:0]  data;
    logic        last;
  } result_word_t;

endpackage

FILE: src/tasw_front.sv
// Byte walker: tracks block position and phase, decodes headers, forms result words.
module tasw_front
  import tasw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [7:0]   archive_byte,
  input  logic         archive_end,
  output logic         push,
  output result_word_t push_word
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_PAD    = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [OFF_W-1:0] block_offset, block_offset_next;
  logic [1:0]       phase, phase_next;
  logic [31:0]      size_accum, size_accum_next;
  logic             octal_stopped, octal_stopped_next;
  logic             dir_flag, dir_flag_next;
  logic             named_flag, named_flag_next;
  logic             all_zero, all_zero_next;
  logic [31:0]      data_left, data_left_next;
  logic [31:0]      data_dec;
  logic             accept;
  logic             in_size;
  logic             is_digit;

  assign accept   = in_valid && in_ready;
  assign in_size  = (block_offset >= OFF_SIZE_FIRST) && (block_offset <= OFF_SIZE_LAST);
  assign is_digit = (archive_byte >= CHAR_ZERO) && (archive_byte <= CHAR_SEVEN);
  assign data_dec = (data_left != 32'd0) ? data_left - 32'd1 : data_left;

  always_comb begin
    block_offset_next  = block_offset + 1'b1;
    phase_next         = phase;
    size_accum_next    = size_accum;
    octal_stopped_next = octal_stopped;
    dir_flag_next      = dir_flag;
    named_flag_next    = named_flag;
    all_zero_next      = all_zero;
    data_left_next     = data_left;
    push               = 1'b0;
    push_word          = '0;
    case (phase)
      PH_HEADER: begin
        if (archive_byte != 8'd0) begin
          all_zero_next = 1'b0;
        end
        if ((block_offset == OFF_NAME || block_offset == OFF_PREFIX) &&
            archive_byte != 8'd0) begin
          named_flag_next = 1'b1;
        end
        if (in_size && !octal_stopped) begin
          if (!is_digit) begin
            octal_stopped_next = 1'b1;
          end else begin
            size_accum_next = {size_accum[28:0], 3'b000} + {29'd0, archive_byte[2:0]};
          end
        end
        if (block_offset == OFF_TYPE) begin
          dir_flag_next = (archive_byte == CHAR_FIVE);
        end
        if (block_offset == OFF_BLOCK_END) begin
          push = accept;
          if (all_zero_next) begin
            push_word.kind = KIND_END;
            phase_next     = PH_DONE;
          end else begin
            push_word.kind   = KIND_ENTRY;
            push_word.size   = size_accum_next;
            push_word.is_dir = dir_flag_next;
            push_word.named  = named_flag_next;
            data_left_next   = size_accum_next;
            phase_next       = (size_accum_next != 32'd0) ? PH_DATA : PH_HEADER;
          end
          size_accum_next    = 32'd0;
          octal_stopped_next = 1'b0;
          dir_flag_next      = 1'b0;
          named_flag_next    = 1'b0;
          all_zero_next      = 1'b1;
        end
      end
      PH_DATA: begin
        push           = accept;
        push_word.kind = KIND_DATA;
        push_word.data = archive_byte;
        data_left_next = data_dec;
        if (data_dec == 32'd0) begin
          push_word.last = 1'b1;
          phase_next     = (block_offset == OFF_BLOCK_END) ? PH_HEADER : PH_PAD;
        end
      end
      PH_PAD: begin
        if (block_offset == OFF_BLOCK_END) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && archive_end)) begin
      block_offset  <= '0;
      phase         <= PH_HEADER;
      size_accum    <= 32'd0;
      octal_stopped <= 1'b0;
      dir_flag      <= 1'b0;
      named_flag    <= 1'b0;
      all_zero      <= 1'b1;
      data_left     <= 32'd0;
    end else if (accept) begin
      block_offset  <= block_offset_next;
      phase         <= phase_next;
      size_accum    <= size_accum_next;
      octal_stopped <= octal_stopped_next;
      dir_flag      <= dir_flag_next;
      named_flag    <= named_flag_next;
      all_zero      <= all_zero_next;
      data_left     <= data_left_next;
    end
  end

`ifndef SYNTHESIS
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && accept) |-> !push)
    else $error("result produced after end of archive");

  a_data_emits: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA && accept) |-> (push && push_word.kind == KIND_DATA))
    else $error("data byte not emitted");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && archive_end) |=> (phase == PH_HEADER && block_offset == '0 && all_zero))
    else $error("walker not reset after last archive byte");
`endif

endmodule

FILE: src/tasw_queue.sv
// Small result queue between the byte walker and the output port.
module tasw_queue
  import tasw_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_word_t push_word,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output result_word_t out_word
);

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  result_word_t       mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               pop;

  assign full      = (count == COUNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("result queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("result queue count did not drop on pop");
`endif

endmodule

FILE: src/tar_archive_stream_walker_core.sv
// Top level of the tar archive stream walker: byte walker plus result queue.
//
// The block takes a tar image one byte per word on the input channel and walks
// it in 512-byte blocks. Each header block yields one entry word (octal size
// from offset 124, directory flag from the typeflag at offset 156, and whether
// name or prefix starts nonzero); each data byte of the entry yields one data
// word, the final one with data_last set; padding gives nothing. An all-zero
// header gives one end-of-archive word, after which bytes are swallowed until
// the byte marked archive_end, which returns the block to its reset state.
// Rate: one input byte per cycle, sustained, as long as the output side keeps
// up. Each result is written into the queue when its byte is accepted.
// Between the walker and the output sits a queue of QUEUE_DEPTH words; in_ready
// drops only while that queue is full, so input and output stall separately.
// Fields of a result that do not belong to its kind read as zero.
module tar_archive_stream_walker_core
  import tasw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = tasw_pkg::QUEUE_DEPTH
)
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  archive_byte,
  input  logic        archive_end,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [31:0] entry_size,
  output logic        entry_is_dir,
  output logic        entry_named,
  output logic [7:0]  data_byte,
  output logic        data_last
);

  logic         push;
  logic         full;
  result_word_t push_word;
  result_word_t out_word;

  // Ready only depends on queue space, never on walker phase.
  assign in_ready = !full;

  tasw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .archive_byte (archive_byte),
    .archive_end  (archive_end),
    .push         (push),
    .push_word    (push_word)
  );

  tasw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign result_kind  = out_word.kind;
  assign entry_size   = out_word.size;
  assign entry_is_dir = out_word.is_dir;
  assign entry_named  = out_word.named;
  assign data_byte    = out_word.data;
  assign data_last    = out_word.last;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the tar archive stream walker core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tasw_pkg::*;

  // Walker phases of the local predictor
  typedef enum logic [1:0] {
    WALK_HEADER,
    WALK_DATA,
    WALK_PAD,
    WALK_DONE
  } walk_state_t;

  // One archive byte as sent, with an optional hand-written expectation for
  // the word it closes (used by the directed rows only)
  typedef struct {
    logic [7:0]   b;
    logic         e;
    bit           typed;
    result_word_t want;
  } tar_byte_t;

  // Directed row: one header block, then a run of body bytes
  typedef struct {
    logic [95:0]  size_txt;
    logic [7:0]   name0;
    logic [7:0]   prefix0;
    logic [7:0]   type_ch;
    logic [7:0]   fill;
    int           hdr_len;
    int           body_len;
    bit           end_mark;
    bit           typed;
    result_word_t want;
  } header_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  archive_byte = 8'h00;
  logic        archive_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] entry_size;
  logic        entry_is_dir;
  logic        entry_named;
  logic [7:0]  data_byte;
  logic        data_last;

  tar_archive_stream_walker_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .archive_byte (archive_byte),
    .archive_end  (archive_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .entry_size   (entry_size),
    .entry_is_dir (entry_is_dir),
    .entry_named  (entry_named),
    .data_byte    (data_byte),
    .data_last    (data_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tar_byte_t    image[$];          // whole byte stream, directed part first
  result_word_t pending_words[$];  // words the walker still owes us
  header_row_t  plan[3];

  int fed = 0;          // bytes accepted so far
  int words_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int cycle_limit = 0;
  int drain_wait = 0;
  int quiet = 0;
  int send_idle;
  int recv_idle;

  // Predictor state
  logic [8:0]  at_off;
  walk_state_t walk_st;
  logic [31:0] oct_acc;
  logic        oct_done;
  logic        saw_dir;
  logic        saw_name;
  logic        hdr_blank;
  logic [31:0] bytes_owed;

  tar_byte_t    cur;
  bit           got_one;
  result_word_t predicted;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void restart_header();
    oct_acc   = '0;
    oct_done  = 1'b0;
    saw_dir   = 1'b0;
    saw_name  = 1'b0;
    hdr_blank = 1'b1;
  endfunction

  function automatic void restart_walker();
    at_off     = '0;
    walk_st    = WALK_HEADER;
    bytes_owed = '0;
    restart_header();
  endfunction

  // Advance the walker by one byte; w is the word it yields, if any.
  task automatic walk_byte(input logic [7:0] b, input logic e, output bit has,
                           output result_word_t w);
    has = 1'b0;
    w   = '0;
    case (walk_st)
      WALK_HEADER: begin
        if (b != 8'h00) hdr_blank = 1'b0;
        if ((at_off == OFF_NAME || at_off == OFF_PREFIX) && b != 8'h00) saw_name = 1'b1;
        // octal size: digits until the first byte outside '0'..'7'
        if (at_off >= OFF_SIZE_FIRST && at_off <= OFF_SIZE_LAST && !oct_done) begin
          if (b < CHAR_ZERO || b > CHAR_SEVEN) oct_done = 1'b1;
          else oct_acc = (oct_acc << 3) + b - CHAR_ZERO;
        end
        if (at_off == OFF_TYPE) saw_dir = (b == CHAR_FIVE);
        if (at_off == OFF_BLOCK_END) begin
          if (hdr_blank) begin
            w.kind  = KIND_END;
            walk_st = WALK_DONE;
          end else begin
            w.kind     = KIND_ENTRY;
            w.size     = oct_acc;
            w.is_dir   = saw_dir;
            w.named    = saw_name;
            bytes_owed = oct_acc;
            walk_st    = (oct_acc != 0) ? WALK_DATA : WALK_HEADER;
          end
          has = 1'b1;
          restart_header();
        end
      end
      WALK_DATA: begin
        w.kind = KIND_DATA;
        w.data = b;
        if (bytes_owed != 0) bytes_owed = bytes_owed - 1;
        if (bytes_owed == 0) begin
          w.last  = 1'b1;
          walk_st = (at_off == OFF_BLOCK_END) ? WALK_HEADER : WALK_PAD;
        end
        has = 1'b1;
      end
      WALK_PAD: begin
        if (at_off == OFF_BLOCK_END) walk_st = WALK_HEADER;
      end
      default: ;
    endcase
    at_off = at_off + 9'd1;
    // the marked last byte puts everything back to the reset state
    if (e) restart_walker();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b, input bit typed,
                                    input result_word_t want);
    tar_byte_t t;
    t.b     = b;
    t.e     = 1'b0;
    t.typed = typed;
    t.want  = want;
    image.push_back(t);
  endfunction

  // Flag the most recent byte as the end of the archive image
  function automatic void mark_end();
    tar_byte_t t;
    t   = image.pop_back();
    t.e = 1'b1;
    image.push_back(t);
  endfunction

  function automatic logic [7:0] header_byte(input logic [95:0] size_txt,
                                             input logic [7:0] name0, input logic [7:0] prefix0,
                                             input logic [7:0] type_ch, input logic [7:0] fill,
                                             input int unsigned o);
    if (o == OFF_NAME) return name0;
    if (o == OFF_PREFIX) return prefix0;
    if (o == OFF_TYPE) return type_ch;
    if (o >= OFF_SIZE_FIRST && o <= OFF_SIZE_LAST)
      return size_txt[95 - 8*(o - OFF_SIZE_FIRST) -: 8];
    return fill;
  endfunction

  // Size text is given right-aligned with its length; store it left-aligned
  // so that the first character lands at offset 124.
  function automatic header_row_t hdr_row(input logic [95:0] txt, input int nch,
                                          input logic [7:0] name0, input logic [7:0] prefix0,
                                          input logic [7:0] type_ch, input logic [7:0] fill,
                                          input int hdr_len, input int body_len,
                                          input bit end_mark, input bit typed,
                                          input logic [1:0] kind, input logic [31:0] size,
                                          input logic dir, input logic named);
    header_row_t r;
    r.size_txt    = txt << (8 * (12 - nch));
    r.name0       = name0;
    r.prefix0     = prefix0;
    r.type_ch     = type_ch;
    r.fill        = fill;
    r.hdr_len     = hdr_len;
    r.body_len    = body_len;
    r.end_mark    = end_mark;
    r.typed       = typed;
    r.want        = '0;
    r.want.kind   = kind;
    r.want.size   = size;
    r.want.is_dir = dir;
    r.want.named  = named;
    return r;
  endfunction

  // Octal size text of nd digits, then a terminator and junk or NULs
  function automatic logic [95:0] octal_field(input int unsigned value, input int nd,
                                              input logic [7:0] term);
    logic [95:0] f;
    logic [7:0]  c;
    f = '0;
    for (int i = 0; i < 12; i++) begin
      if (i < nd) c = 8'(CHAR_ZERO + ((value >> (3 * (nd - 1 - i))) & 7));
      else if (i == nd) c = term;
      else c = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'h00;
      f[95 - 8*i -: 8] = c;
    end
    return f;
  endfunction

  task automatic build_directed();
    header_row_t r;
    plan[0] = hdr_row(96'd0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 512, 5, 1, 1,
                      KIND_END, 32'd0, 1'b0, 1'b0);            // blank block, junk, end
    plan[1] = hdr_row("100000000000", 12, "w", 8'h00, CHAR_ZERO, 8'h00, 512, 0, 0, 1,
                      KIND_ENTRY, 32'd0, 1'b0, 1'b1);          // wraps to zero
    plan[2] = hdr_row("777777777777", 12, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 512, 3, 1, 1,
                      KIND_ENTRY, 32'hFFFF_FFFF, 1'b0, 1'b1);  // twelve digits, data cut off
    foreach (plan[i]) begin
      r = plan[i];
      for (int o = 0; o < r.hdr_len; o++)
        push_byte(header_byte(r.size_txt, r.name0, r.prefix0, r.type_ch, r.fill, o),
                  r.typed && o == OFF_BLOCK_END, r.want);
      for (int o = 0; o < r.body_len; o++) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      if (r.end_mark) mark_end();
    end
  endtask

  // Mostly well-formed archives with random content; some noise and some
  // archives broken off in a header or in the middle of data.
  task automatic build_random();
    int          sz;
    int          need;
    int          nd;
    int          n;
    int          v;
    bit          cut;
    bit          noisy;
    logic [95:0] txt;
    logic [7:0]  nm;
    logic [7:0]  px;
    logic [7:0]  ty;
    logic [7:0]  tm;
    while (image.size() < 1750) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 700);
        repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        mark_end();
      end else begin
        cut = 1'b0;
        for (int k = $urandom_range(1, 2); k > 0 && !cut; k--) begin
          if ($urandom_range(0, 7) == 0) begin
            // garbage header, size unknown: trail off and end the image
            repeat (512) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            repeat ($urandom_range(0, 40)) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            mark_end();
            cut = 1'b1;
          end else begin
            case ($urandom_range(0, 19))
              14, 15, 16: sz = 0;
              17:         sz = 512;
              18, 19:     sz = $urandom_range(400, 530);
              default:    sz = $urandom_range(0, 40);
            endcase
            need = 0;
            v = sz;
            while (v != 0) begin
              need++;
              v = v >> 3;
            end
            nd = $urandom_range(need, 12);
            case ($urandom_range(0, 3))
              2:       tm = 8'h20;
              3:       tm = 8'($urandom_range(8'h38, 8'hFF));
              default: tm = 8'h00;
            endcase
            txt = octal_field(sz, nd, tm);
            nm = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            px = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
            case ($urandom_range(0, 7))
              0, 1:    ty = CHAR_FIVE;
              2:       ty = 8'($urandom_range(0, 255));
              default: ty = CHAR_ZERO;
            endcase
            noisy = ($urandom_range(0, 2) == 0);
            for (int o = 0; o < 512; o++)
              push_byte(header_byte(txt, nm, px, ty,
                                    noisy ? 8'($urandom_range(0, 255)) : 8'h00, o),
                        1'b0, '0);
            if (sz != 0 && $urandom_range(0, 5) == 0) begin
              repeat ($urandom_range(1, sz)) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
              mark_end();
              cut = 1'b1;
            end else begin
              // data, then padding up to the block boundary
              repeat (sz + (512 - sz % 512) % 512)
                push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
          end
        end
        if (!cut) begin
          case ($urandom_range(0, 2))
            0: begin
              repeat (512) push_byte(8'h00, 1'b0, '0);
              repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            1: repeat (1024) push_byte(8'h00, 1'b0, '0);
            default: repeat ($urandom_range(1, 511))
              push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
          endcase
          mark_end();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t: word %0d: %s", $realtime, words_seen, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_word();
    result_word_t want;
    if (pending_words.size() == 0) begin
      flag_mismatch($sformatf("unexpected word of kind %0d", result_kind));
    end else begin
      want = pending_words.pop_front();
      compare_field("result_kind", 32'(result_kind), 32'(want.kind));
      compare_field("entry_size", entry_size, want.size);
      compare_field("entry_is_dir", 32'(entry_is_dir), 32'(want.is_dir));
      compare_field("entry_named", 32'(entry_named), 32'(want.named));
      compare_field("data_byte", 32'(data_byte), 32'(want.data));
      compare_field("data_last", 32'(data_last), 32'(want.last));
    end
    words_seen++;
  endtask

  initial begin
    restart_walker();
    build_directed();
    build_random();
    cycle_limit = 100000 + 40 * image.size();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Drive, predict and check, all from the one clock edge so that the order
  // of pushes and pops on the expectation queue never depends on scheduling.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      cycles++;

      // output side first: words in flight were predicted on earlier edges
      if (out_valid && out_ready) check_word();

      if (in_valid && in_ready) begin
        cur = image[fed];
        walk_byte(cur.b, cur.e, got_one, predicted);
        // directed rows may carry a hand-written word instead
        if (got_one) pending_words.push_back(cur.typed ? cur.want : predicted);
        fed++;
      end

      // pacing: receiver-heavy idling, then sender-heavy, then none
      case (fed * 3 / image.size())
        0: begin
          send_idle = 24;
          recv_idle = 50;
        end
        1: begin
          send_idle = 50;
          recv_idle = 24;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase

      // valid holds until the word is taken
      if (!(in_valid && !in_ready)) begin
        if (fed < image.size() && $urandom_range(0, 99) >= send_idle) begin
          in_valid     <= 1'b1;
          archive_byte <= image[fed].b;
          archive_end  <= image[fed].e;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);

      // drain: wait for the expectation queue to empty and stay empty
      if (fed == image.size()) begin
        drain_wait++;
        if (pending_words.size() == 0) quiet++;
        else quiet = 0;
      end

      if (cycles > cycle_limit) begin
        flag_mismatch($sformatf("timed out after %0d cycles", cycles));
        $display("Mismatches found");
        $finish;
      end else if (quiet == 16 || drain_wait == 400) begin
        if (pending_words.size() != 0)
          flag_mismatch($sformatf("%0d expected words never came", pending_words.size()));
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
src/tasw_pkg.sv
src/tasw_front.sv
src/tasw_queue.sv
src/tar_archive_stream_walker_core.sv
test/testbench.sv
